// File: sv/owm_pkg.sv
// Shared types, codes and timing table for the 1-Wire bus master.
// Used by the front queue, the step engine, the result queue and the top level.
// No dependencies.
package owm_pkg;

	// Command codes on the input side
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	// Bus phase codes
	localparam int PH_W = 4;
	localparam logic [PH_W-1:0] PH_IDLE    = 4'd0;
	localparam logic [PH_W-1:0] PH_RST_LOW = 4'd1;
	localparam logic [PH_W-1:0] PH_RST_SMP = 4'd2;
	localparam logic [PH_W-1:0] PH_RST_REC = 4'd3;
	localparam logic [PH_W-1:0] PH_WR_LOW  = 4'd4;
	localparam logic [PH_W-1:0] PH_WR_SLOT = 4'd5;
	localparam logic [PH_W-1:0] PH_RD_LOW  = 4'd6;
	localparam logic [PH_W-1:0] PH_RD_WAIT = 4'd7;
	localparam logic [PH_W-1:0] PH_RD_REST = 4'd8;

	localparam int US_W  = 9;
	localparam int TPU_W = 10;
	localparam logic [TPU_W-1:0] TPU_RESET = 10'd50;

	// Queue depth on either side
	localparam int QDEPTH = 2;

	typedef logic [1:0] op_t;

	// One classified input item
	typedef struct packed {
		op_t        op;
		logic       starts;
		logic [7:0] data;
		logic       line;
	} item_t;

	// One result item
	typedef struct packed {
		logic       line_low;
		logic       busy;
		logic       done;
		logic       present;
		logic [7:0] rdata;
	} res_t;

	// Phase length in microseconds
	function automatic logic [US_W-1:0] phase_us(input logic [PH_W-1:0] ph);
		logic [US_W-1:0] us;
		unique case (ph)
			PH_RST_LOW: us = 9'd485;
			PH_RST_SMP: us = 9'd65;
			PH_RST_REC: us = 9'd420;
			PH_WR_LOW:  us = 9'd2;
			PH_WR_SLOT: us = 9'd65;
			PH_RD_LOW:  us = 9'd2;
			PH_RD_WAIT: us = 9'd13;
			PH_RD_REST: us = 9'd45;
			default:    us = 9'd0;
		endcase
		return us;
	endfunction

endpackage

// File: sv/onewire_bus_master.sv
// 1-Wire bus master top level: front queue, step engine, result queue.
// A pushed tick is registered in the front queue, then stepped once the result queue has room and registered there.
// Throughput: one tick per cycle, as long as the result queue has room for the result of each step.
// Reset: both queues empty, bus idle, counters and shift byte zero, 50 ticks per us.
// Depends on owm_pkg, owm_front, owm_engine, owm_outq.
module onewire_bus_master (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] command,
	input  logic [7:0] data_byte,
	input  logic       line_in,
	input  logic       cfg_wr_en,
	input  logic [9:0] cfg_wr_data,
	output logic       empty,
	input  logic       pop,
	output logic       line_low,
	output logic       busy_res,
	output logic       done_res,
	output logic       device_present,
	output logic [7:0] rx_byte
);
	import owm_pkg::*;

	logic  head_valid;
	item_t head;
	logic  rq_full;
	logic  fire;
	res_t  step_res;
	res_t  out_res;

	// Step whenever a tick waits and the result queue has room
	assign fire = head_valid && !rq_full;

	owm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.command   (command),
		.data_byte (data_byte),
		.line_in   (line_in),
		.head_valid(head_valid),
		.head      (head),
		.head_take (fire)
	);

	owm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fire       (fire),
		.item       (head),
		.res        (step_res)
	);

	owm_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (fire),
		.wr_res(step_res),
		.q_full(rq_full),
		.pop   (pop),
		.empty (empty),
		.head  (out_res)
	);

	assign line_low       = out_res.line_low;
	assign busy_res       = out_res.busy;
	assign done_res       = out_res.done;
	assign device_present = out_res.present;
	assign rx_byte        = out_res.rdata;

`ifndef SYNTHESIS
	// A finished command leaves the bus idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && done_res |-> !busy_res)
		else $error("done result while still busy");

	// The line is driven low only during a command
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && line_low |-> busy_res)
		else $error("line driven low while idle");

	// The front queue fills only after a transfer in
	a_full_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("front queue filled without a transfer");

	// Every stepped tick lands in the result queue
	a_fire_src: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> !empty)
		else $error("stepped tick lost before the result queue");
`endif

endmodule

// File: sv/owm_front.sv
// Front queue of the 1-Wire bus master: accepts ticks and classifies the command.
// Depends on owm_pkg.
module owm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [1:0]        command,
	input  logic [7:0]        data_byte,
	input  logic              line_in,
	output logic              head_valid,
	output owm_pkg::item_t    head,
	input  logic              head_take
);
	import owm_pkg::*;

	item_t      mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	item_t      cls;
	logic       do_push;
	logic       do_pop;

	// Classify the incoming command
	always_comb begin
		cls.data = data_byte;
		cls.line = line_in;
		unique case (command)
			CMD_RESET: begin cls.op = CMD_RESET; cls.starts = 1'b1; end
			CMD_WRITE: begin cls.op = CMD_WRITE; cls.starts = 1'b1; end
			CMD_READ:  begin cls.op = CMD_READ;  cls.starts = 1'b1; end
			default:   begin cls.op = CMD_NONE;  cls.starts = 1'b0; end
		endcase
	end

	assign full       = (count_q == 2'(QDEPTH));
	assign head_valid = (count_q != 2'd0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = head_take && head_valid;

	// Store a transfer
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: sv/owm_engine.sv
// Step engine of the 1-Wire bus master: advances bus timing by one tick per item.
// Depends on owm_pkg.
module owm_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [owm_pkg::TPU_W-1:0]  cfg_wr_data,
	input  logic                       fire,
	input  owm_pkg::item_t             item,
	output owm_pkg::res_t              res
);
	import owm_pkg::*;

	logic [TPU_W-1:0] tpu_q;
	logic [PH_W-1:0]  phase_q;
	logic [US_W-1:0]  us_cnt_q;
	logic [TPU_W-1:0] presc_q;
	logic [2:0]       bit_pos_q;
	logic [7:0]       shift_q;
	logic             present_q;

	logic [PH_W-1:0]  phase_n;
	logic [US_W-1:0]  us_cnt_n;
	logic [TPU_W-1:0] presc_n;
	logic [2:0]       bit_pos_n;
	logic [7:0]       shift_n;
	logic             present_n;
	logic             done_n;

	logic [TPU_W-1:0] tpu_eff;
	logic [TPU_W:0]   presc_inc;
	logic [US_W-1:0]  us_inc;
	logic             us_tick;
	logic             ph_end;

	assign tpu_eff   = (tpu_q == '0) ? TPU_W'(1) : tpu_q;
	assign presc_inc = {1'b0, presc_q} + (TPU_W+1)'(1);
	assign us_tick   = (presc_inc >= {1'b0, tpu_eff});
	assign us_inc    = us_cnt_q + US_W'(1);
	assign ph_end    = us_tick && (us_inc >= phase_us(phase_q));

	// Compute the next state for one tick
	always_comb begin
		phase_n   = phase_q;
		us_cnt_n  = us_cnt_q;
		presc_n   = presc_q;
		bit_pos_n = bit_pos_q;
		shift_n   = shift_q;
		present_n = present_q;
		done_n    = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.starts) begin
				us_cnt_n = '0;
				presc_n  = '0;
				unique case (item.op)
					CMD_WRITE: begin
						phase_n   = PH_WR_LOW;
						shift_n   = item.data;
						bit_pos_n = 3'd0;
					end
					CMD_READ: begin
						phase_n   = PH_RD_LOW;
						shift_n   = 8'd0;
						bit_pos_n = 3'd0;
					end
					default: phase_n = PH_RST_LOW;
				endcase
			end
		end else if (us_tick) begin
			presc_n  = '0;
			us_cnt_n = us_inc;
			if (ph_end) begin
				us_cnt_n = '0;
				unique case (phase_q)
					PH_RST_LOW: phase_n = PH_RST_SMP;
					PH_RST_SMP: begin
						present_n = ~item.line;
						phase_n   = PH_RST_REC;
					end
					PH_WR_LOW:  phase_n = PH_WR_SLOT;
					PH_WR_SLOT: begin
						shift_n = {1'b0, shift_q[7:1]};
						if (bit_pos_q == 3'd7) begin
							bit_pos_n = 3'd0;
							phase_n   = PH_IDLE;
							done_n    = 1'b1;
						end else begin
							bit_pos_n = bit_pos_q + 3'd1;
							phase_n   = PH_WR_LOW;
						end
					end
					PH_RD_LOW:  phase_n = PH_RD_WAIT;
					PH_RD_WAIT: begin
						shift_n = {item.line, shift_q[7:1]};
						phase_n = PH_RD_REST;
					end
					PH_RD_REST: begin
						if (bit_pos_q == 3'd7) begin
							bit_pos_n = 3'd0;
							phase_n   = PH_IDLE;
							done_n    = 1'b1;
						end else begin
							bit_pos_n = bit_pos_q + 3'd1;
							phase_n   = PH_RD_LOW;
						end
					end
					default: begin
						phase_n = PH_IDLE;
						done_n  = 1'b1;
					end
				endcase
			end
		end else begin
			presc_n = presc_inc[TPU_W-1:0];
		end
	end

	// Form the result from the updated state
	always_comb begin
		case (phase_n) inside
			PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: res.line_low = 1'b1;
			PH_WR_SLOT:                      res.line_low = ~shift_n[0];
			default:                         res.line_low = 1'b0;
		endcase
		res.busy    = (phase_n != PH_IDLE);
		res.done    = done_n;
		res.present = present_n;
		res.rdata   = shift_n;
	end

	// Hold the timing register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpu_q <= TPU_RESET;
		end else if (cfg_wr_en) begin
			tpu_q <= cfg_wr_data;
		end
	end

	// Advance the bus state on each tick taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			us_cnt_q  <= '0;
			presc_q   <= '0;
			bit_pos_q <= 3'd0;
			shift_q   <= 8'd0;
			present_q <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_n;
			us_cnt_q  <= us_cnt_n;
			presc_q   <= presc_n;
			bit_pos_q <= bit_pos_n;
			shift_q   <= shift_n;
			present_q <= present_n;
		end
	end

endmodule

// File: sv/owm_outq.sv
// Result queue of the 1-Wire bus master: holds results until they are popped.
// Depends on owm_pkg.
module owm_outq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  owm_pkg::res_t  wr_res,
	output logic           q_full,
	input  logic           pop,
	output logic           empty,
	output owm_pkg::res_t  head
);
	import owm_pkg::*;

	res_t       mem_q [QDEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign q_full = (count_q == 2'(QDEPTH));
	assign empty  = (count_q == 2'd0);
	assign head   = mem_q[rd_ptr_q];
	assign do_pop = pop && !empty;

	// Store a result
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_res;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en)  wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({wr_en, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
